// ===== rtl/ncm_pkg.sv =====
// ----------------------------------------------------------------------------
// ncm_pkg
// Shared widths, codes and stage payload types of the normalization cube map
// texel generator.
// ----------------------------------------------------------------------------
package ncm_pkg;

    localparam int MAX_SIDE = 1024;
    localparam int SIDE_MIN = 2;

    localparam int CFG_W   = 11;
    localparam int FACE_W  = 3;
    localparam int COORD_W = 10;
    localparam int TEXEL_W = 32;
    localparam int CH_W    = 8;

    localparam int LANES  = 3;
    localparam int MAG_W  = $clog2(MAX_SIDE);
    localparam int VEC_W  = MAG_W + 2;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int LEN_W  = SQ_W + 2;
    localparam int RHS_W  = SQ_W + 16;
    localparam int Q_W    = CH_W - 1;
    localparam int PROD_W = LEN_W + 2 * Q_W;
    localparam int LIN_W  = LEN_W + Q_W;

    localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(256);
    localparam logic [MAG_W-1:0] D_RESET    = MAG_W'(255);

    localparam logic [FACE_W-1:0] FACE_X_POS = FACE_W'(0);
    localparam logic [FACE_W-1:0] FACE_X_NEG = FACE_W'(1);
    localparam logic [FACE_W-1:0] FACE_Y_POS = FACE_W'(2);
    localparam logic [FACE_W-1:0] FACE_Y_NEG = FACE_W'(3);
    localparam logic [FACE_W-1:0] FACE_Z_POS = FACE_W'(4);
    localparam logic [FACE_W-1:0] FACE_Z_NEG = FACE_W'(5);

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } comp_t;

    typedef struct packed {
        logic                  bad;
        comp_t [LANES-1:0]     comp;
    } vec_t;

    typedef struct packed {
        logic             neg;
        logic [RHS_W-1:0] rhs;
    } lane_in_t;

    typedef struct packed {
        logic                  bad;
        logic [LEN_W-1:0]      len;
        lane_in_t [LANES-1:0]  lane;
    } norm_t;

endpackage

// ===== rtl/ncm_vector.sv =====
// ----------------------------------------------------------------------------
// ncm_vector
// First pipeline stage: clamps the texel coordinates, forms the integer
// direction for the face and splits each component into sign and magnitude.
// ----------------------------------------------------------------------------
module ncm_vector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ncm_pkg::MAG_W-1:0]   side_d,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ncm_pkg::FACE_W-1:0]  face,
    input  logic [ncm_pkg::COORD_W-1:0] column,
    input  logic [ncm_pkg::COORD_W-1:0] row,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ncm_pkg::vec_t               out_vec
);
    import ncm_pkg::*;

    function automatic comp_t to_comp(logic signed [VEC_W-1:0] v);
        comp_t            c;
        logic [VEC_W-1:0] a;
        a = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
        c.neg = v[VEC_W-1];
        c.mag = a[MAG_W-1:0];
        return c;
    endfunction

    logic                    valid_reg;
    vec_t                    vec_reg;
    vec_t                    vec_next;
    logic [MAG_W-1:0]        col_c;
    logic [MAG_W-1:0]        row_c;
    logic signed [VEC_W-1:0] dp;
    logic signed [VEC_W-1:0] dn;
    logic signed [VEC_W-1:0] sp;
    logic signed [VEC_W-1:0] sn;
    logic signed [VEC_W-1:0] tp;
    logic signed [VEC_W-1:0] tn;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    always_comb
    begin
        col_c = (MAG_W'(column) > side_d) ? side_d : MAG_W'(column);
        row_c = (MAG_W'(row) > side_d) ? side_d : MAG_W'(row);
        dp    = signed'({2'b00, side_d});
        dn    = -dp;
        sp    = signed'({1'b0, col_c, 1'b0}) - dp;
        sn    = -sp;
        tp    = signed'({1'b0, row_c, 1'b0}) - dp;
        tn    = -tp;
        vec_next.bad = 1'b0;
        vx = '0;
        vy = '0;
        vz = '0;
        case (face)
            FACE_X_POS:
            begin
                vx = dp; vy = tn; vz = sn;
            end
            FACE_X_NEG:
            begin
                vx = dn; vy = tn; vz = sp;
            end
            FACE_Y_POS:
            begin
                vx = sp; vy = dp; vz = tp;
            end
            FACE_Y_NEG:
            begin
                vx = sp; vy = dn; vz = tn;
            end
            FACE_Z_POS:
            begin
                vx = sp; vy = tn; vz = dp;
            end
            FACE_Z_NEG:
            begin
                vx = sn; vy = tn; vz = dn;
            end
            default:
            begin
                vec_next.bad = 1'b1;
            end
        endcase
        vec_next.comp[0] = to_comp(vx);
        vec_next.comp[1] = to_comp(vy);
        vec_next.comp[2] = to_comp(vz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

endmodule

// ===== rtl/ncm_square.sv =====
// ----------------------------------------------------------------------------
// ncm_square
// Two pipeline stages: squares of the component magnitudes, then the squared
// length and the scaled square 65025*c*c of each component.
// ----------------------------------------------------------------------------
module ncm_square (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ncm_pkg::vec_t  in_vec,
    output logic           out_valid,
    input  logic           out_ready,
    output ncm_pkg::norm_t out_norm
);
    import ncm_pkg::*;

    typedef struct packed {
        logic                        bad;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][SQ_W-1:0]  sq;
    } sq_stage_t;

    logic      a_valid_reg;
    logic      b_valid_reg;
    logic      a_ready;
    logic      b_ready;
    sq_stage_t a_reg;
    sq_stage_t a_next;
    norm_t     b_reg;
    norm_t     b_next;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_norm  = b_reg;

    always_comb
    begin
        a_next.bad = in_vec.bad;
        for (int i = 0; i < LANES; i++)
        begin
            a_next.neg[i] = in_vec.comp[i].neg;
            a_next.sq[i]  = SQ_W'(in_vec.comp[i].mag) * SQ_W'(in_vec.comp[i].mag);
        end
    end

    always_comb
    begin
        b_next.bad = a_reg.bad;
        b_next.len = LEN_W'(a_reg.sq[0]) + LEN_W'(a_reg.sq[1]) + LEN_W'(a_reg.sq[2]);
        for (int i = 0; i < LANES; i++)
        begin
            // 65025 = 2^16 - 2^9 + 1
            b_next.lane[i].neg = a_reg.neg[i];
            b_next.lane[i].rhs = (RHS_W'(a_reg.sq[i]) << 16) - (RHS_W'(a_reg.sq[i]) << 9)
                                 + RHS_W'(a_reg.sq[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

endmodule

// ===== rtl/ncm_search.sv =====
// ----------------------------------------------------------------------------
// ncm_search
// Seven-stage bit-by-bit search of each 8-bit channel code by exact compare
// of 4*q*q*len against 65025*c*c, one code bit per stage, then texel packing.
// ----------------------------------------------------------------------------
module ncm_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ncm_pkg::norm_t              in_norm,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ncm_pkg::TEXEL_W-1:0] texel
);
    import ncm_pkg::*;

    typedef struct packed {
        logic              neg;
        logic [Q_W-1:0]    q;
        logic [PROD_W-1:0] p2;
        logic [LIN_W-1:0]  p1;
        logic [RHS_W-1:0]  rhs;
    } lane_t;

    typedef struct packed {
        logic               bad;
        logic [LEN_W-1:0]   len;
        lane_t [LANES-1:0]  lane;
    } srch_t;

    // p2 holds q*q*len and p1 holds q*len for the bits decided so far
    function automatic lane_t step_lane(lane_t cur, logic [LEN_W-1:0] len, int b);
        lane_t               nxt;
        logic [PROD_W-1:0]   ptry;
        logic [PROD_W+1:0]   lhs;
        logic [PROD_W+1:0]   rhs;
        logic                fit;
        ptry = cur.p2 + (PROD_W'(cur.p1) << (b + 1)) + (PROD_W'(len) << (2 * b));
        lhs  = {ptry, 2'b00};
        rhs  = (PROD_W+2)'(cur.rhs);
        fit  = cur.neg ? (lhs < rhs) : (lhs <= rhs);
        nxt  = cur;
        if (fit)
        begin
            nxt.q  = cur.q | (Q_W'(1) << b);
            nxt.p2 = ptry;
            nxt.p1 = cur.p1 + (LIN_W'(len) << b);
        end
        return nxt;
    endfunction

    function automatic logic [CH_W-1:0] lane_code(lane_t l);
        return l.neg ? {1'b0, ~l.q} : {1'b1, l.q};
    endfunction

    logic [Q_W-1:0] valid_reg;
    logic [Q_W:0]   rdy;
    srch_t          data_reg   [Q_W];
    srch_t          stage_in   [Q_W];
    srch_t          stage_next [Q_W];
    srch_t          init;
    srch_t          last;

    always_comb
    begin
        init.bad = in_norm.bad;
        init.len = in_norm.len;
        for (int i = 0; i < LANES; i++)
        begin
            init.lane[i].neg = in_norm.lane[i].neg;
            init.lane[i].rhs = in_norm.lane[i].rhs;
            init.lane[i].q   = '0;
            init.lane[i].p2  = '0;
            init.lane[i].p1  = '0;
        end
    end

    assign rdy[Q_W]  = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[Q_W-1];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic prev_valid;

        if (k == 0)
        begin : g_first
            assign stage_in[k] = init;
            assign prev_valid  = in_valid;
        end
        else
        begin : g_next
            assign stage_in[k] = data_reg[k-1];
            assign prev_valid  = valid_reg[k-1];
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_comb
        begin
            stage_next[k] = stage_in[k];
            for (int i = 0; i < LANES; i++)
            begin
                stage_next[k].lane[i] = step_lane(stage_in[k].lane[i], stage_in[k].len,
                                                  Q_W - 1 - k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && prev_valid)
            begin
                data_reg[k] <= stage_next[k];
            end
        end
    end

    assign last  = data_reg[Q_W-1];
    assign texel = last.bad ? '0 : {ALPHA_OPAQUE, lane_code(last.lane[0]),
                                    lane_code(last.lane[1]), lane_code(last.lane[2])};

endmodule

// ===== rtl/normalizer_cube_map_texel_top.sv =====
// ----------------------------------------------------------------------------
// normalizer_cube_map_texel_top
// Normalization cube map texel generator. Takes one (face, column, row) per
// cycle and returns one packed A8R8G8B8 texel per cycle while the output is
// not stalled. The ten register stages are one for the face direction, two
// for squares and the squared length, and seven for the exact code search,
// one code bit per stage for all three channels. Stalls hold each stage only
// as far as needed, so empty stages keep filling. side_length is to be
// written on the cfg port only while no texel is in flight; the block does
// not enforce this. Values below 2 act as 2 and above 1024 as 1024.
// ----------------------------------------------------------------------------
module normalizer_cube_map_texel_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ncm_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ncm_pkg::FACE_W-1:0]  face,
    input  logic [ncm_pkg::COORD_W-1:0] column,
    input  logic [ncm_pkg::COORD_W-1:0] row,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ncm_pkg::TEXEL_W-1:0] texel
);
    import ncm_pkg::*;

    logic [MAG_W-1:0] side_d_reg;
    logic [MAG_W-1:0] side_d_next;
    logic             vec_valid;
    logic             vec_ready;
    vec_t             vec;
    logic             norm_valid;
    logic             norm_ready;
    norm_t            norm;

    assign cfg_ready = 1'b1;

    // side minus one, with the side clamped to its legal range
    always_comb
    begin
        if (cfg_data < CFG_W'(SIDE_MIN))
        begin
            side_d_next = MAG_W'(SIDE_MIN - 1);
        end
        else if (cfg_data > CFG_W'(MAX_SIDE))
        begin
            side_d_next = MAG_W'(MAX_SIDE - 1);
        end
        else
        begin
            side_d_next = MAG_W'(cfg_data - CFG_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_d_reg <= D_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            side_d_reg <= side_d_next;
        end
    end

    ncm_vector u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .side_d    (side_d_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .face      (face),
        .column    (column),
        .row       (row),
        .out_valid (vec_valid),
        .out_ready (vec_ready),
        .out_vec   (vec)
    );

    ncm_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid),
        .in_ready  (vec_ready),
        .in_vec    (vec),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_norm  (norm)
    );

    ncm_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_norm   (norm),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .texel     (texel)
    );

endmodule

// ===== rtl/ncm_checker.sv =====
// ----------------------------------------------------------------------------
// ncm_checker
// Port-level checks of the cube map texel generator, bound to the top level.
// ----------------------------------------------------------------------------
module ncm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [ncm_pkg::TEXEL_W-1:0] texel
);
    import ncm_pkg::*;

    // stalled result transfer keeps valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // stalled result transfer keeps its texel
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(texel))
        else $error("texel changed while stalled");

    // opaque alpha unless the face is unknown
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (texel[31:24] == ALPHA_OPAQUE) || (texel == '0))
        else $error("texel alpha not opaque");

    // a unit vector has one component of at least 1/sqrt(3)
    a_dominant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (texel != '0) && cfg_ready |->
            (texel[23:16] >= 8'd200) || (texel[23:16] <= 8'd55) ||
            (texel[15:8] >= 8'd200) || (texel[15:8] <= 8'd55) ||
            (texel[7:0] >= 8'd200) || (texel[7:0] <= 8'd55))
        else $error("texel has no dominant component");

endmodule

bind normalizer_cube_map_texel_top ncm_checker u_checker (.*);
